@@ sv/bq_pkg.sv @@
// ----------------------------------------------------------------------------
// bq_pkg: shared types, constants and arithmetic helpers
// Widths, coefficient slot codes, the cell-to-cell hand-off type and the
// Q15 product and clamp helpers used by the cascade.
// ----------------------------------------------------------------------------
package bq_pkg;

  localparam int NUM_STAGES = 16;
  localparam int SLOTS      = 6;
  localparam int SAMPLE_W   = 16;
  localparam int STAGE_W    = 5;
  localparam int SLOT_W     = 3;
  localparam int PROD_W     = 2 * SAMPLE_W;
  localparam int QSHIFT     = 15;
  localparam int TERM_W     = PROD_W - QSHIFT;
  // Five Q15 terms of at most 2^15 in magnitude need three bits of headroom.
  localparam int ACC_W      = SAMPLE_W + 3;
  localparam int QMAX       = 32767;
  localparam int IN_DATA_W  = 40;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [TERM_W-1:0]   term_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic [STAGE_W-1:0]         stage_t;
  typedef logic [SLOT_W-1:0]          slot_t;

  localparam slot_t SLOT_B0   = 3'd0;
  localparam slot_t SLOT_B1   = 3'd1;
  localparam slot_t SLOT_B2   = 3'd2;
  localparam slot_t SLOT_A1   = 3'd3;
  localparam slot_t SLOT_A2   = 3'd4;
  localparam slot_t SLOT_GAIN = 3'd5;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEF   = 1'b1;

  localparam stage_t OUT_GAIN_STAGE = STAGE_W'(NUM_STAGES);

  localparam sample_t QMAX_S = SAMPLE_W'(QMAX);
  localparam sample_t QMIN_S = -SAMPLE_W'(QMAX);

  typedef struct packed {
    logic    en;
    stage_t  stage;
    slot_t   slot;
    sample_t value;
  } coef_wr_t;

  typedef struct packed {
    logic    valid;
    sample_t data;
  } hand_t;

  // Floor of product / 2^15: arithmetic shift keeps the upper bits.
  function automatic term_t qterm(input prod_t p);
    qterm = p[PROD_W-1:QSHIFT];
  endfunction

  function automatic sample_t clampq(input acc_t v);
    if (v > acc_t'(QMAX)) begin
      clampq = QMAX_S;
    end else if (v < -acc_t'(QMAX)) begin
      clampq = QMIN_S;
    end else begin
      clampq = v[SAMPLE_W-1:0];
    end
  endfunction

endpackage

@@ sv/bq_cell.sv @@
// ----------------------------------------------------------------------------
// bq_cell: one Direct Form I biquad section
// Holds the section's gain and five coefficients and its four delay values.
// A single multiplier forms the six products one after another; the clamped
// result is handed to the next cell in the cycle the last term is summed.
// ----------------------------------------------------------------------------
module bq_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  bq_pkg::stage_t   stage_id,
  input  bq_pkg::coef_wr_t wr,
  input  bq_pkg::hand_t    in_h,
  output bq_pkg::hand_t    out_h
);
  import bq_pkg::*;

  localparam logic [2:0] LAST_STEP = 3'd6;

  sample_t    coef_r [SLOTS];
  sample_t    xd1_r, xd2_r, yd1_r, yd2_r;
  logic       busy_r;
  logic [2:0] step_r;
  sample_t    v_r;
  sample_t    x0_r;
  prod_t      prod_r;
  acc_t       acc_r;

  sample_t mul_a, mul_b;
  acc_t    term_ext;
  acc_t    acc_nxt;
  sample_t y0;

  always_comb begin
    case (step_r)
      3'd0: begin
        mul_a = coef_r[SLOT_GAIN];
        mul_b = v_r;
      end
      3'd1: begin
        mul_a = coef_r[SLOT_B1];
        mul_b = xd1_r;
      end
      3'd2: begin
        mul_a = coef_r[SLOT_B0];
        mul_b = x0_r;
      end
      3'd3: begin
        mul_a = coef_r[SLOT_B2];
        mul_b = xd2_r;
      end
      3'd4: begin
        mul_a = coef_r[SLOT_A1];
        mul_b = yd1_r;
      end
      3'd5: begin
        mul_a = coef_r[SLOT_A2];
        mul_b = yd2_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // The product registered last cycle is summed now, but at step 1 the sum is
  // cleared; the feedback terms arrive in the last two steps and are subtracted.
  always_comb begin
    term_ext = ACC_W'(qterm(prod_r));
    case (step_r) inside
      3'd1:         acc_nxt = '0;
      3'd5, 3'd6:   acc_nxt = acc_r - term_ext;
      default:      acc_nxt = acc_r + term_ext;
    endcase
    y0 = clampq(acc_nxt);
  end

  assign out_h.valid = busy_r && (step_r == LAST_STEP);
  assign out_h.data  = y0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      xd1_r  <= '0;
      xd2_r  <= '0;
      yd1_r  <= '0;
      yd2_r  <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        coef_r[i] <= '0;
      end
    end else begin
      if (wr.en && (wr.stage == stage_id) && (wr.slot < SLOT_W'(SLOTS))) begin
        coef_r[wr.slot] <= wr.value;
      end
      if (in_h.valid) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          xd2_r  <= xd1_r;
          xd1_r  <= x0_r;
          yd2_r  <= yd1_r;
          yd1_r  <= y0;
        end
        step_r <= step_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_h.valid) begin
      v_r <= in_h.data;
    end
    prod_r <= mul_a * mul_b;
    acc_r  <= acc_nxt;
    if (step_r == 3'd1) begin
      x0_r <= clampq(term_ext);
    end
  end

endmodule

@@ sv/biquad_cascade_df1_q15_core.sv @@
// ----------------------------------------------------------------------------
// biquad_cascade_df1_q15_core: cascade of Q15 Direct Form I biquads
// Sixteen biquad cells in a chain followed by a saturating output gain.
// ----------------------------------------------------------------------------
// A request with tuser 1 writes one coefficient (a stage's b0, b1, b2, a1,
// a2 or input gain, or the output gain when the stage is 16); it gives no
// result. A request with tuser 0 filters one sample: each cell forms its
// six products in turn with its own multiplier and hands the result to the
// next cell. The next request can be taken once the result is loaded into the
// output register, which waits on out_tready while full. The output register
// holds a finished result while the next request is already being taken.
// All coefficients and delay values are zero after reset.
module biquad_cascade_df1_q15_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [15:0] sample_in, [20:16] coef_stage, [23:21] coef_slot, [39:24] coef_value
  input  logic [bq_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] req_type
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [15:0] sample_out
  output logic [bq_pkg::SAMPLE_W-1:0]   out_tdata
);
  import bq_pkg::*;

  sample_t  sample_in;
  stage_t   coef_stage;
  slot_t    coef_slot;
  sample_t  coef_value;
  logic     in_acc;
  coef_wr_t wr;
  hand_t    chain [NUM_STAGES+1];

  logic    busy_r;
  sample_t gain_r;
  prod_t   gprod_r;
  logic    gvalid_r;
  logic    out_valid_r;
  sample_t out_data_r;
  logic    out_load;

  assign sample_in  = in_tdata[15:0];
  assign coef_stage = in_tdata[20:16];
  assign coef_slot  = in_tdata[23:21];
  assign coef_value = in_tdata[39:24];

  assign in_tready = !busy_r;
  assign in_acc    = in_tvalid && in_tready;

  // The most negative code is stored as its clamped neighbor.
  always_comb begin
    wr.en    = in_acc && (in_tuser == REQ_COEF);
    wr.stage = coef_stage;
    wr.slot  = coef_slot;
    wr.value = (coef_value < QMIN_S) ? QMIN_S : coef_value;
  end

  assign chain[0].valid = in_acc && (in_tuser == REQ_SAMPLE);
  assign chain[0].data  = sample_in;

  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_cell
    bq_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .stage_id (STAGE_W'(i)),
      .wr       (wr),
      .in_h     (chain[i]),
      .out_h    (chain[i+1])
    );
  end

  assign out_load = gvalid_r && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      gain_r      <= '0;
      gvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr.en && (wr.stage == OUT_GAIN_STAGE)) begin
        gain_r <= wr.value;
      end
      if (chain[0].valid) begin
        busy_r <= 1'b1;
      end else if (out_load) begin
        busy_r <= 1'b0;
      end
      if (chain[NUM_STAGES].valid) begin
        gvalid_r <= 1'b1;
      end else if (out_load) begin
        gvalid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chain[NUM_STAGES].valid) begin
      gprod_r <= gain_r * chain[NUM_STAGES].data;
    end
    if (out_load) begin
      out_data_r <= clampq(ACC_W'(qterm(gprod_r)));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
